### src/assert_macros.svh
// Assertion macros for the checker of the complex arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk and disabled while aresetn is low.
`define CAU_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled while aresetn is low.
`define CAU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/cau_pkg.sv
// Shared types, widths and codes of the complex arithmetic unit.
package cau_pkg;

    // Number format: signed fixed point, WORD_BITS wide with FRACTION_BITS fraction bits.
    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int ACTION_BITS   = 4;

    // Internal widths: full products, sums of two products, and the divider remainder.
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int REM_BITS  = SUM_BITS + FRACTION_BITS;

    // Command queue between the front and the execution pipeline (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Execution stages: three setup stages, the divider entry, one per quotient bit, output.
    localparam int EXEC_STAGES = WORD_BITS + 5;
    localparam int CAPACITY    = 1 + QUEUE_DEPTH + EXEC_STAGES;

    // Saturation limits, as magnitudes and as words.
    localparam logic [SUM_BITS-1:0] MAG_MAX =
        {{(SUM_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic [SUM_BITS-1:0] MAG_MIN = MAG_MAX + SUM_BITS'(1);
    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    // Action codes on the input channel.
    localparam logic [ACTION_BITS-1:0] ACT_ADD        = 4'd0;
    localparam logic [ACTION_BITS-1:0] ACT_ADD_SCALAR = 4'd1;
    localparam logic [ACTION_BITS-1:0] ACT_SUB        = 4'd2;
    localparam logic [ACTION_BITS-1:0] ACT_SUB_SCALAR = 4'd3;
    localparam logic [ACTION_BITS-1:0] ACT_MUL        = 4'd4;
    localparam logic [ACTION_BITS-1:0] ACT_MUL_SCALAR = 4'd5;
    localparam logic [ACTION_BITS-1:0] ACT_DIV        = 4'd6;
    localparam logic [ACTION_BITS-1:0] ACT_DIV_SCALAR = 4'd7;
    localparam logic [ACTION_BITS-1:0] ACT_NEGATE     = 4'd8;
    localparam logic [ACTION_BITS-1:0] ACT_COMPARE    = 4'd9;

    // Operation kinds after classification.
    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_NONE = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_SUB  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_MUL  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_DIV  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_NEG  = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_CMP  = 3'd6;

    typedef struct packed {
        logic [ACTION_BITS-1:0]      action;
        logic signed [WORD_BITS-1:0] left_real;
        logic signed [WORD_BITS-1:0] left_imag;
        logic signed [WORD_BITS-1:0] right_real;
        logic signed [WORD_BITS-1:0] right_imag;
    } cau_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_real;
        logic signed [WORD_BITS-1:0] result_imag;
        logic                        is_equal;
        logic                        divide_by_zero;
        logic                        overflowed;
    } cau_out_t;

    // Classification of one item.
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 scalar;
    } class_t;

    // Classified command handed from the front to the execution pipeline.
    typedef struct packed {
        class_t                      cls;
        logic signed [WORD_BITS-1:0] ar;
        logic signed [WORD_BITS-1:0] ai;
        logic signed [WORD_BITS-1:0] br;
        logic signed [WORD_BITS-1:0] bi;
    } cmd_t;

endpackage

### src/cau_front.sv
// Input stage: accepts items, classifies the action and holds one command.
module cau_front import cau_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  cau_in_t s_data,
    output logic    cmd_valid,
    input  logic    cmd_ready,
    output cmd_t    cmd
);

    logic   front_valid_reg, front_valid_next;
    cmd_t   cmd_reg;
    class_t cls_next;
    logic   take;

    // Decode the action code into an operation kind and a scalar flag.
    always_comb begin
        cls_next.kind   = KIND_NONE;
        cls_next.scalar = 1'b0;
        case (s_data.action)
            ACT_ADD:        cls_next.kind = KIND_ADD;
            ACT_ADD_SCALAR: begin
                cls_next.kind   = KIND_ADD;
                cls_next.scalar = 1'b1;
            end
            ACT_SUB:        cls_next.kind = KIND_SUB;
            ACT_SUB_SCALAR: begin
                cls_next.kind   = KIND_SUB;
                cls_next.scalar = 1'b1;
            end
            ACT_MUL:        cls_next.kind = KIND_MUL;
            ACT_MUL_SCALAR: begin
                cls_next.kind   = KIND_MUL;
                cls_next.scalar = 1'b1;
            end
            ACT_DIV:        cls_next.kind = KIND_DIV;
            ACT_DIV_SCALAR: begin
                cls_next.kind   = KIND_DIV;
                cls_next.scalar = 1'b1;
            end
            ACT_NEGATE:     cls_next.kind = KIND_NEG;
            ACT_COMPARE:    cls_next.kind = KIND_CMP;
            default:        cls_next.kind = KIND_NONE;
        endcase
    end

    // The holding register takes a new item whenever it is empty or drains this cycle.
    assign s_ready   = !front_valid_reg || cmd_ready;
    assign take      = s_valid && s_ready;
    assign cmd_valid = front_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        front_valid_next = take ? 1'b1 : (front_valid_reg && !cmd_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg.cls <= cls_next;
            cmd_reg.ar  <= s_data.left_real;
            cmd_reg.ai  <= s_data.left_imag;
            cmd_reg.br  <= s_data.right_real;
            cmd_reg.bi  <= s_data.right_imag;
        end
    end

endmodule

### src/cau_queue.sv
// Small command queue that decouples the front from the execution pipeline.
module cau_queue import cau_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_en,
    output cmd_t pop_cmd
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push, pop;

    // Flow control from the fill count.
    assign push_ready = count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_en && pop_valid;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    // Pointers wrap naturally since the depth is a power of two.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/cau_exec.sv
// Execution pipeline: products, combination, magnitudes, pipelined divider and saturation.
module cau_exec import cau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    output logic     cmd_pop,
    input  cmd_t     cmd,
    output logic     m_valid,
    input  logic     m_ready,
    output cau_out_t m_data
);

    logic advance;

    // Stage A: operands and products.
    logic                        a_valid_reg;
    class_t                      a_cls_reg;
    logic signed [WORD_BITS-1:0] a_ar_reg, a_ai_reg, a_br_reg, a_bi_reg;
    logic signed [PROD_BITS-1:0] a_p_rr_reg, a_p_ii_reg, a_p_ir_reg, a_p_ri_reg;
    logic signed [PROD_BITS-1:0] a_p_bb_reg, a_p_dd_reg;

    // Stage B: signed values of both parts and the divisor.
    logic                       b_valid_reg;
    logic signed [SUM_BITS-1:0] b_val_reg [2];
    logic signed [SUM_BITS-1:0] b_val_next [2];
    logic signed [SUM_BITS-1:0] b_den_reg, b_den_next;
    logic                       b_shift_reg, b_shift_next;
    logic                       b_div_reg, b_div_next;
    logic                       b_eq_reg, b_eq_next;
    logic signed [SUM_BITS-1:0] x_ar, x_ai, x_br, x_bi;
    logic signed [SUM_BITS-1:0] x_rr, x_ii, x_ir, x_ri, x_bb, x_dd;

    // Stage C: magnitudes and result signs.
    logic                c_valid_reg;
    logic [SUM_BITS-1:0] c_mag_reg [2];
    logic [SUM_BITS-1:0] c_mag_next [2];
    logic [1:0]          c_neg_reg, c_neg_next;
    logic [SUM_BITS-1:0] c_den_reg, c_den_next;
    logic                c_div_reg, c_eq_reg;

    // Divider entry (index 0) and one stage per quotient bit.
    logic [WORD_BITS:0]   st_valid_reg;
    logic [WORD_BITS:0]   st_div_reg, st_dz_reg, st_eq_reg;
    logic [1:0]           st_neg_reg [0:WORD_BITS];
    logic [1:0]           st_ovf_reg [0:WORD_BITS];
    logic [SUM_BITS-1:0]  st_den_reg [0:WORD_BITS-1];
    logic [REM_BITS-1:0]  st_r_reg   [0:WORD_BITS][2];
    logic [WORD_BITS-1:0] st_q_reg   [0:WORD_BITS][2];
    logic [REM_BITS-1:0]  st_r_next  [1:WORD_BITS][2];
    logic [WORD_BITS-1:0] st_q_next  [1:WORD_BITS][2];
    logic [REM_BITS-1:0]  d_r_next   [2];
    logic [1:0]           d_ovf_next;
    logic                 d_dz_next;

    // Output register.
    logic                 out_valid_reg;
    cau_out_t             out_data_reg, out_data_next;
    logic [WORD_BITS-1:0] pack_val [2];
    logic [1:0]           pack_sat;

    // The whole pipeline moves unless a finished result is held by the receiver.
    assign advance = !out_valid_reg || m_ready;
    assign cmd_pop = advance && cmd_valid;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg   <= cmd_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            st_valid_reg  <= {st_valid_reg[WORD_BITS-1:0], c_valid_reg};
            out_valid_reg <= st_valid_reg[WORD_BITS];
        end
    end

    // Sign-extended operands and products for stage B.
    assign x_ar = SUM_BITS'(a_ar_reg);
    assign x_ai = SUM_BITS'(a_ai_reg);
    assign x_br = SUM_BITS'(a_br_reg);
    assign x_bi = SUM_BITS'(a_bi_reg);
    assign x_rr = SUM_BITS'(a_p_rr_reg);
    assign x_ii = SUM_BITS'(a_p_ii_reg);
    assign x_ir = SUM_BITS'(a_p_ir_reg);
    assign x_ri = SUM_BITS'(a_p_ri_reg);
    assign x_bb = SUM_BITS'(a_p_bb_reg);
    assign x_dd = SUM_BITS'(a_p_dd_reg);

    // Stage B: combine operands or products according to the operation.
    always_comb begin
        b_val_next[0] = '0;
        b_val_next[1] = '0;
        b_den_next    = '0;
        b_shift_next  = 1'b0;
        b_div_next    = 1'b0;
        b_eq_next     = 1'b0;
        case (a_cls_reg.kind)
            KIND_ADD: begin
                b_val_next[0] = x_ar + x_br;
                b_val_next[1] = a_cls_reg.scalar ? x_ai : x_ai + x_bi;
            end
            KIND_SUB: begin
                b_val_next[0] = x_ar - x_br;
                b_val_next[1] = a_cls_reg.scalar ? x_ai : x_ai - x_bi;
            end
            KIND_MUL: begin
                b_shift_next  = 1'b1;
                b_val_next[0] = a_cls_reg.scalar ? x_rr : x_rr - x_ii;
                b_val_next[1] = a_cls_reg.scalar ? x_ir : x_ir + x_ri;
            end
            KIND_DIV: begin
                b_div_next    = 1'b1;
                b_val_next[0] = a_cls_reg.scalar ? x_ar : x_rr + x_ii;
                b_val_next[1] = a_cls_reg.scalar ? x_ai : x_ir - x_ri;
                b_den_next    = a_cls_reg.scalar ? x_br : x_bb + x_dd;
            end
            KIND_NEG: begin
                b_val_next[0] = -x_ar;
                b_val_next[1] = -x_ai;
            end
            KIND_CMP: begin
                b_eq_next = (a_ar_reg == a_br_reg) && (a_ai_reg == a_bi_reg);
            end
            default: begin
            end
        endcase
    end

    // Stage C: magnitudes, product scaling and the sign of each result part.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            c_neg_next[l] = b_val_reg[l][SUM_BITS-1] ^ b_den_reg[SUM_BITS-1];
            c_mag_next[l] = b_val_reg[l][SUM_BITS-1] ? SUM_BITS'(-b_val_reg[l])
                                                     : SUM_BITS'(b_val_reg[l]);
            if (b_shift_reg) begin
                c_mag_next[l] = c_mag_next[l] >> FRACTION_BITS;
            end
        end
        c_den_next = b_den_reg[SUM_BITS-1] ? SUM_BITS'(-b_den_reg) : SUM_BITS'(b_den_reg);
    end

    // Divider entry: zero divisor, quotient range check and scaled dividend.
    always_comb begin
        d_dz_next = c_div_reg && (c_den_reg == '0);
        for (int l = 0; l < 2; l++) begin
            d_ovf_next[l] = c_div_reg &&
                ((c_mag_reg[l] >> (WORD_BITS - FRACTION_BITS)) >= c_den_reg);
            d_r_next[l]   = c_div_reg ? (REM_BITS'(c_mag_reg[l]) << FRACTION_BITS)
                                      : REM_BITS'(c_mag_reg[l]);
        end
    end

    // Restoring divider: stage s decides quotient bit WORD_BITS - s for both parts.
    for (genvar s = 1; s <= WORD_BITS; s++) begin : g_div
        localparam int BIT = WORD_BITS - s;
        localparam logic [REM_BITS-1:0] LOW_MASK = (REM_BITS'(1) << BIT) - REM_BITS'(1);
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [REM_BITS-1:0] hi;
            logic [REM_BITS:0]   diff;
            logic                ge;
            assign hi   = st_r_reg[s-1][l] >> BIT;
            assign diff = {1'b0, hi} - {1'b0, REM_BITS'(st_den_reg[s-1])};
            assign ge   = st_div_reg[s-1] && !diff[REM_BITS];
            assign st_r_next[s][l] = ge ? ((diff[REM_BITS-1:0] << BIT) |
                                           (st_r_reg[s-1][l] & LOW_MASK))
                                        : st_r_reg[s-1][l];
            assign st_q_next[s][l] = st_q_reg[s-1][l] |
                                     (ge ? (WORD_BITS'(1) << BIT) : '0);
        end
    end

    // Final saturation of each part.
    for (genvar l = 0; l < 2; l++) begin : g_pack
        logic [SUM_BITS-1:0] mag;
        logic [SUM_BITS-1:0] lim;
        logic                neg;
        assign neg = st_neg_reg[WORD_BITS][l];
        assign mag = st_div_reg[WORD_BITS] ? SUM_BITS'(st_q_reg[WORD_BITS][l])
                                           : st_r_reg[WORD_BITS][l][SUM_BITS-1:0];
        assign lim = neg ? MAG_MIN : MAG_MAX;
        assign pack_sat[l] = st_ovf_reg[WORD_BITS][l] || st_dz_reg[WORD_BITS] || (mag > lim);
        assign pack_val[l] = pack_sat[l] ? (neg ? WORD_MIN : WORD_MAX)
                                         : (neg ? -mag[WORD_BITS-1:0] : mag[WORD_BITS-1:0]);
    end

    always_comb begin
        out_data_next.result_real    = pack_val[0];
        out_data_next.result_imag    = pack_val[1];
        out_data_next.is_equal       = st_eq_reg[WORD_BITS];
        out_data_next.divide_by_zero = st_dz_reg[WORD_BITS];
        out_data_next.overflowed     = |pack_sat;
    end

    // Payload registers of all stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            a_cls_reg  <= cmd.cls;
            a_ar_reg   <= cmd.ar;
            a_ai_reg   <= cmd.ai;
            a_br_reg   <= cmd.br;
            a_bi_reg   <= cmd.bi;
            a_p_rr_reg <= PROD_BITS'(cmd.ar) * PROD_BITS'(cmd.br);
            a_p_ii_reg <= PROD_BITS'(cmd.ai) * PROD_BITS'(cmd.bi);
            a_p_ir_reg <= PROD_BITS'(cmd.ai) * PROD_BITS'(cmd.br);
            a_p_ri_reg <= PROD_BITS'(cmd.ar) * PROD_BITS'(cmd.bi);
            a_p_bb_reg <= PROD_BITS'(cmd.br) * PROD_BITS'(cmd.br);
            a_p_dd_reg <= PROD_BITS'(cmd.bi) * PROD_BITS'(cmd.bi);

            b_val_reg[0] <= b_val_next[0];
            b_val_reg[1] <= b_val_next[1];
            b_den_reg    <= b_den_next;
            b_shift_reg  <= b_shift_next;
            b_div_reg    <= b_div_next;
            b_eq_reg     <= b_eq_next;

            c_mag_reg[0] <= c_mag_next[0];
            c_mag_reg[1] <= c_mag_next[1];
            c_neg_reg    <= c_neg_next;
            c_den_reg    <= c_den_next;
            c_div_reg    <= b_div_reg;
            c_eq_reg     <= b_eq_reg;

            st_div_reg    <= {st_div_reg[WORD_BITS-1:0], c_div_reg};
            st_dz_reg     <= {st_dz_reg[WORD_BITS-1:0], d_dz_next};
            st_eq_reg     <= {st_eq_reg[WORD_BITS-1:0], c_eq_reg};
            st_neg_reg[0] <= c_neg_reg;
            st_ovf_reg[0] <= d_ovf_next;
            st_den_reg[0] <= c_den_reg;
            for (int l = 0; l < 2; l++) begin
                st_r_reg[0][l] <= d_r_next[l];
                st_q_reg[0][l] <= '0;
            end
            // The divisor is only needed up to the last quotient stage.
            for (int s = 1; s < WORD_BITS; s++) begin
                st_den_reg[s] <= st_den_reg[s-1];
            end
            for (int s = 1; s <= WORD_BITS; s++) begin
                st_neg_reg[s] <= st_neg_reg[s-1];
                st_ovf_reg[s] <= st_ovf_reg[s-1];
                for (int l = 0; l < 2; l++) begin
                    st_r_reg[s][l] <= st_r_next[s][l];
                    st_q_reg[s][l] <= st_q_next[s][l];
                end
            end

            out_data_reg <= out_data_next;
        end
    end

endmodule

### src/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front, command queue and execution pipeline.
//
// Input channel s_valid/s_ready/s_data carries an action code and two complex operands
// in signed Q16.16; the result channel m_valid/m_ready/m_data returns both result parts
// and the equal, divide-by-zero and overflow flags, one result per input transfer, in order.
// One transfer is accepted per cycle while the receiver keeps up. Each item passes through the
// front register, the command queue, stages A, B and C, the divider entry and the output register;
// the pipeline length is set by the restoring divider, one quotient bit per stage, which every
// item passes through so that all actions share the same latency.
// When m_ready is low the finished result is held and the execution pipeline stops;
// the front register and the four-entry command queue keep accepting transfers until
// they fill, then s_ready drops.
// aresetn is synchronous and active low; it empties the front, the queue and the
// pipeline. No clearing pass is needed and items are accepted right after reset.
module complex_arithmetic_unit_core import cau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cau_out_t m_data
);

    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    logic q_valid, q_pop;
    cmd_t q_cmd;

    // Accept and classify.
    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Decoupling queue.
    cau_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (q_valid),
        .pop_en     (q_pop),
        .pop_cmd    (q_cmd)
    );

    // Arithmetic.
    cau_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### src/cau_checker.sv
// Port-level checker of the complex arithmetic unit, bound to the top level.
`include "assert_macros.svh"

module cau_checker import cau_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input cau_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input cau_out_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 2);

    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             in_xfer, out_xfer;

    // Count transfers taken in but not yet delivered.
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg + {{(CNT_W - 1){1'b0}}, in_xfer}
                                     - {{(CNT_W - 1){1'b0}}, out_xfer};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result stays put.
    `CAU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    // No result without an outstanding input transfer.
    `CAU_ASSERT_NOW(a_no_phantom, m_valid, inflight_reg != '0, "result without pending input")
    // The block never holds more items than it has room for.
    `CAU_ASSERT_NOW(a_capacity, s_valid || !s_valid, inflight_reg <= CNT_W'(CAPACITY), "too many items in flight")
    // A result with the equal flag set carries zero parts and no other flag.
    `CAU_ASSERT_NOW(a_cmp_clean, m_valid && m_data.is_equal, m_data.result_real == '0 && m_data.result_imag == '0 && !m_data.overflowed && !m_data.divide_by_zero, "equal flag with other result content")
    // A zero divisor always reports saturation.
    `CAU_ASSERT_NOW(a_dz_ovf, m_valid && m_data.divide_by_zero, m_data.overflowed, "divide by zero without overflow")

    // Input payload is only observed through the transfer count.
    logic unused_in;
    assign unused_in = ^s_data;

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);
